@@ rtl/qnl_pkg.sv @@
// Shared constants, payload types and stage records of the quaternion nlerp unit.
package qnl_pkg;

  localparam int NUM_LANES  = 4;
  localparam int COMP_W     = 16;
  localparam int BLEND_W    = 17;
  localparam int DIFF_W     = COMP_W + 1;
  localparam int PROD_W     = 34;
  localparam int FRAC_SHIFT = 16;
  localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
  localparam int M_W        = 18;
  localparam int SQ_W       = 34;
  localparam int PAIR_W     = SQ_W + 1;
  localparam int S_W        = PAIR_W + 1;
  localparam int QUO_W      = 31;
  localparam int RAD_W      = QUO_W + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 1;

  localparam int BLEND_STAGES  = 3;
  localparam int ENERGY_STAGES = 3;
  localparam int DIV_STAGES    = QUO_W;
  localparam int SQRT_STEPS    = ROOT_W;
  localparam int SQRT_STAGES   = SQRT_STEPS + 1;
  localparam int LATENCY       = BLEND_STAGES + ENERGY_STAGES + DIV_STAGES + SQRT_STAGES;

  localparam logic signed [COMP_W-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [M_W-1:0]    mid_t;

  typedef struct packed {
    comp_t              from_w;
    comp_t              from_x;
    comp_t              from_y;
    comp_t              from_z;
    comp_t              end_w;
    comp_t              end_x;
    comp_t              end_y;
    comp_t              end_z;
    logic [BLEND_W-1:0] blend;
  } req_t;

  typedef struct packed {
    comp_t out_w;
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    logic  degenerate;
  } res_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            neg;
  } sq_lane_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    logic           degen;
  } div_ctl_t;

  typedef struct packed {
    logic [S_W-1:0]   rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             neg;
  } ratio_t;

  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic                neg;
  } sqrt_lane_t;

endpackage

@@ rtl/qnl_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface qnl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/quaternion_nlerp_unit.sv @@
// Top level of the quaternion normalized linear interpolation unit.
//
//   channel  side    payload         meaning
//   item     sink    qnl_pkg::req_t  start and end quaternion, blend factor
//   result   source  qnl_pkg::res_t  normalized quaternion, degenerate flag
//
// One request can enter each cycle while item.ready is high.
// The pipeline includes the 31-stage quotient pipeline and the 17-stage root and rounding pipeline.
// Reset clears the valid chain and the valid flag of the output holding register.
// A stalled result moves into the holding register; item.ready then drops until it is taken.
module quaternion_nlerp_unit (
  input  logic          clk,
  input  logic          rst,
  qnl_stream_if.sink    item,
  qnl_stream_if.source  result
);
  localparam int NL = qnl_pkg::NUM_LANES;
  localparam int LT = qnl_pkg::LATENCY;

  logic                adv;
  logic [LT-1:0]       vld;
  logic                skid_valid;
  qnl_pkg::res_t       skid;
  qnl_pkg::res_t       pipe_res;
  qnl_pkg::comp_t      start_comp [NL];
  qnl_pkg::comp_t      end_comp [NL];
  qnl_pkg::mid_t       mid [NL];
  qnl_pkg::sq_lane_t   sq_lane [NL];
  qnl_pkg::div_ctl_t   ctl;
  qnl_pkg::ratio_t     ratio [NL];
  logic                ratio_degen;

  always_comb begin
    start_comp[0] = item.data.from_w;
    start_comp[1] = item.data.from_x;
    start_comp[2] = item.data.from_y;
    start_comp[3] = item.data.from_z;
    end_comp[0]   = item.data.end_w;
    end_comp[1]   = item.data.end_x;
    end_comp[2]   = item.data.end_y;
    end_comp[3]   = item.data.end_z;
  end

  assign adv        = !skid_valid;
  assign item.ready = adv;

  qnl_blend u_blend (
    .clk        (clk),
    .adv        (adv),
    .start_comp (start_comp),
    .end_comp   (end_comp),
    .blend      (item.data.blend),
    .mid        (mid)
  );

  qnl_energy u_energy (
    .clk  (clk),
    .adv  (adv),
    .mid  (mid),
    .lane (sq_lane),
    .ctl  (ctl)
  );

  qnl_divider u_divider (
    .clk     (clk),
    .adv     (adv),
    .sq_lane (sq_lane),
    .ctl_in  (ctl),
    .ratio   (ratio),
    .degen   (ratio_degen)
  );

  qnl_isqrt u_isqrt (
    .clk      (clk),
    .adv      (adv),
    .ratio    (ratio),
    .degen_in (ratio_degen),
    .res      (pipe_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LT-2:0], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[LT-1] && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid <= pipe_res;
    end
  end

  assign result.valid = skid_valid || vld[LT-1];
  assign result.data  = skid_valid ? skid : pipe_res;

`ifndef NO_ASSERTIONS
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
      $rose(skid_valid) |-> $past(vld[LT-1] && !result.ready))
    else $error("holding register filled without a stalled result");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
      result.valid && result.data.degenerate |->
        result.data.out_w == '0 && result.data.out_x == '0 &&
        result.data.out_y == '0 && result.data.out_z == '0)
    else $error("degenerate result carries nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
      result.valid |->
        result.data.out_w <= qnl_pkg::ONE_Q14 && result.data.out_w >= -qnl_pkg::ONE_Q14 &&
        result.data.out_x <= qnl_pkg::ONE_Q14 && result.data.out_x >= -qnl_pkg::ONE_Q14 &&
        result.data.out_y <= qnl_pkg::ONE_Q14 && result.data.out_y >= -qnl_pkg::ONE_Q14 &&
        result.data.out_z <= qnl_pkg::ONE_Q14 && result.data.out_z >= -qnl_pkg::ONE_Q14)
    else $error("result component beyond unit magnitude");
`endif
endmodule

@@ rtl/qnl_blend.sv @@
// Three-stage linear blend of four quaternion components, rounded to the intermediate grid.
module qnl_blend (
  input  logic                                clk,
  input  logic                                adv,
  input  qnl_pkg::comp_t                      start_comp [qnl_pkg::NUM_LANES],
  input  qnl_pkg::comp_t                      end_comp [qnl_pkg::NUM_LANES],
  input  logic [qnl_pkg::BLEND_W-1:0]         blend,
  output qnl_pkg::mid_t                       mid [qnl_pkg::NUM_LANES]
);
  localparam int NL   = qnl_pkg::NUM_LANES;
  localparam int SUMW = qnl_pkg::PROD_W + 1;
  localparam int EXTW = SUMW - qnl_pkg::COMP_W - qnl_pkg::FRAC_SHIFT;

  logic signed [qnl_pkg::DIFF_W-1:0] diff [NL];
  qnl_pkg::comp_t                    f1 [NL];
  qnl_pkg::comp_t                    f2 [NL];
  logic [qnl_pkg::BLEND_W-1:0]       t1;
  logic signed [qnl_pkg::PROD_W-1:0] prod [NL];
  logic signed [SUMW-1:0]            prod_full [NL];
  logic [SUMW-1:0]                   acc [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      prod_full[i] = $signed({1'b0, t1}) * diff[i];
      acc[i] = {{EXTW{f2[i][qnl_pkg::COMP_W-1]}}, f2[i], {qnl_pkg::FRAC_SHIFT{1'b0}}}
             + {prod[i][qnl_pkg::PROD_W-1], prod[i]}
             + SUMW'(qnl_pkg::ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1 <= blend;
      for (int i = 0; i < NL; i++) begin
        diff[i] <= {end_comp[i][qnl_pkg::COMP_W-1], end_comp[i]}
                 - {start_comp[i][qnl_pkg::COMP_W-1], start_comp[i]};
        f1[i]   <= start_comp[i];
        f2[i]   <= f1[i];
        prod[i] <= prod_full[i][qnl_pkg::PROD_W-1:0];
        mid[i]  <= acc[i][qnl_pkg::FRAC_SHIFT +: qnl_pkg::M_W];
      end
    end
  end
endmodule

@@ rtl/qnl_energy.sv @@
// Three-stage squared magnitude of the blended quaternion with zero detection.
module qnl_energy (
  input  logic                clk,
  input  logic                adv,
  input  qnl_pkg::mid_t       mid [qnl_pkg::NUM_LANES],
  output qnl_pkg::sq_lane_t   lane [qnl_pkg::NUM_LANES],
  output qnl_pkg::div_ctl_t   ctl
);
  localparam int NL = qnl_pkg::NUM_LANES;

  logic signed [2*qnl_pkg::M_W-1:0] sq_full [NL];
  logic [qnl_pkg::SQ_W-1:0]         sq1 [NL];
  logic [qnl_pkg::SQ_W-1:0]         sq2 [NL];
  logic [NL-1:0]                    neg1;
  logic [NL-1:0]                    neg2;
  logic [qnl_pkg::PAIR_W-1:0]       pair0;
  logic [qnl_pkg::PAIR_W-1:0]       pair1;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      sq_full[i] = mid[i] * mid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        sq1[i]       <= sq_full[i][qnl_pkg::SQ_W-1:0];
        neg1[i]      <= mid[i][qnl_pkg::M_W-1];
        sq2[i]       <= sq1[i];
        lane[i].sq   <= sq2[i];
        lane[i].neg  <= neg2[i];
      end
      neg2      <= neg1;
      pair0     <= {1'b0, sq1[0]} + {1'b0, sq1[1]};
      pair1     <= {1'b0, sq1[2]} + {1'b0, sq1[3]};
      ctl.s     <= {1'b0, pair0} + {1'b0, pair1};
      ctl.degen <= (pair0 == '0) && (pair1 == '0);
    end
  end
endmodule

@@ rtl/qnl_divider.sv @@
// Restoring division pipeline, one quotient bit per stage, giving floor(sq * 2^30 / s) per lane.
module qnl_divider (
  input  logic                clk,
  input  logic                adv,
  input  qnl_pkg::sq_lane_t   sq_lane [qnl_pkg::NUM_LANES],
  input  qnl_pkg::div_ctl_t   ctl_in,
  output qnl_pkg::ratio_t     ratio [qnl_pkg::NUM_LANES],
  output logic                degen
);
  localparam int NL = qnl_pkg::NUM_LANES;
  localparam int NS = qnl_pkg::DIV_STAGES;
  localparam int SW = qnl_pkg::S_W;
  localparam int QW = qnl_pkg::QUO_W;

  qnl_pkg::div_ctl_t  ctl_q [NS];
  qnl_pkg::div_ctl_t  ctl_src [NS];
  qnl_pkg::div_lane_t lane_q [NS][NL];
  qnl_pkg::div_lane_t lane_src [NS][NL];
  qnl_pkg::div_lane_t lane_nxt [NS][NL];

  always_comb begin
    logic [SW:0] trial;
    logic [SW:0] rest;
    logic        ge;
    ctl_src[0] = ctl_in;
    for (int i = 0; i < NL; i++) begin
      lane_src[0][i].rem = SW'(sq_lane[i].sq);
      lane_src[0][i].quo = '0;
      lane_src[0][i].neg = sq_lane[i].neg;
    end
    for (int k = 1; k < NS; k++) begin
      ctl_src[k]  = ctl_q[k-1];
      lane_src[k] = lane_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      for (int i = 0; i < NL; i++) begin
        trial = (k == 0) ? {1'b0, lane_src[k][i].rem} : {lane_src[k][i].rem, 1'b0};
        ge    = trial >= {1'b0, ctl_src[k].s};
        rest  = trial - {1'b0, ctl_src[k].s};
        lane_nxt[k][i].rem = ge ? rest[SW-1:0] : trial[SW-1:0];
        lane_nxt[k][i].quo = {lane_src[k][i].quo[QW-2:0], ge};
        lane_nxt[k][i].neg = lane_src[k][i].neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_q  <= ctl_src;
      lane_q <= lane_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ratio[i].quo = lane_q[NS-1][i].quo;
      ratio[i].neg = lane_q[NS-1][i].neg;
    end
  end

  assign degen = ctl_q[NS-1].degen;
endmodule

@@ rtl/qnl_isqrt.sv @@
// Integer square root pipeline, one root bit per stage, with final rounding and sign restore.
module qnl_isqrt (
  input  logic                clk,
  input  logic                adv,
  input  qnl_pkg::ratio_t     ratio [qnl_pkg::NUM_LANES],
  input  logic                degen_in,
  output qnl_pkg::res_t       res
);
  localparam int NL = qnl_pkg::NUM_LANES;
  localparam int NS = qnl_pkg::SQRT_STEPS;
  localparam int RW = qnl_pkg::RAD_W;
  localparam int MW = qnl_pkg::SQ_REM_W;
  localparam int TW = qnl_pkg::ROOT_W;

  qnl_pkg::sqrt_lane_t lane_q [NS][NL];
  qnl_pkg::sqrt_lane_t lane_src [NS][NL];
  qnl_pkg::sqrt_lane_t lane_nxt [NS][NL];
  logic [NS-1:0]       degen_q;
  logic [TW:0]         rnd [NL];
  logic [TW-1:0]       half [NL];
  qnl_pkg::comp_t      comp [NL];

  always_comb begin
    logic [MW+1:0] x;
    logic [MW+1:0] trial;
    logic [MW+1:0] rest;
    logic          ge;
    for (int i = 0; i < NL; i++) begin
      lane_src[0][i].rad  = {1'b0, ratio[i].quo};
      lane_src[0][i].rem  = '0;
      lane_src[0][i].root = '0;
      lane_src[0][i].neg  = ratio[i].neg;
    end
    for (int k = 1; k < NS; k++) begin
      lane_src[k] = lane_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      for (int i = 0; i < NL; i++) begin
        x     = {lane_src[k][i].rem, lane_src[k][i].rad[RW-1 -: 2]};
        trial = {1'b0, lane_src[k][i].root, 2'b01};
        ge    = x >= trial;
        rest  = x - trial;
        lane_nxt[k][i].rem  = ge ? rest[MW-1:0] : x[MW-1:0];
        lane_nxt[k][i].root = {lane_src[k][i].root[TW-2:0], ge};
        lane_nxt[k][i].rad  = {lane_src[k][i].rad[RW-3:0], 2'b00};
        lane_nxt[k][i].neg  = lane_src[k][i].neg;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rnd[i]  = {1'b0, lane_q[NS-1][i].root} + 1'b1;
      half[i] = rnd[i][TW:1];
      comp[i] = lane_q[NS-1][i].neg ? qnl_pkg::comp_t'(-half[i]) : qnl_pkg::comp_t'(half[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_q  <= lane_nxt;
      degen_q <= {degen_q[NS-2:0], degen_in};
      if (degen_q[NS-1]) begin
        res.out_w <= '0;
        res.out_x <= '0;
        res.out_y <= '0;
        res.out_z <= '0;
      end else begin
        res.out_w <= comp[0];
        res.out_x <= comp[1];
        res.out_y <= comp[2];
        res.out_z <= comp[3];
      end
      res.degenerate <= degen_q[NS-1];
    end
  end
endmodule

@@ tb/quaternion_nlerp_unit_tb.sv @@
// Self-checking testbench for the quaternion normalized linear interpolation unit.
module quaternion_nlerp_unit_tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst;

  qnl_stream_if #(.payload_t(qnl_pkg::req_t)) item_ch ();
  qnl_stream_if #(.payload_t(qnl_pkg::res_t)) result_ch ();

  quaternion_nlerp_unit dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  qnl_pkg::res_t  pending_results[$];
  int             mismatch_count;
  int             cycle_count;
  bit             sender_idle;
  bit             receiver_idle;
  int             receiver_hold;
  qnl_pkg::res_t  want;
  qnl_pkg::comp_t want_c[4];
  qnl_pkg::comp_t got_c[4];
  string          lane_name[4] = '{"out_w", "out_x", "out_y", "out_z"};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic qnl_pkg::res_t blend_and_normalize(input qnl_pkg::req_t r);
    qnl_pkg::res_t  q;
    qnl_pkg::comp_t fc[4];
    qnl_pkg::comp_t ec[4];
    qnl_pkg::comp_t oc[4];
    longint         m[4];
    longint         v;
    longint         t;
    longint         mag;
    longint         s;
    logic [127:0]   s_wide;
    logic [127:0]   k_wide;
    logic [127:0]   target;
    int             lo;
    int             hi;
    int             mid;
    fc = '{r.from_w, r.from_x, r.from_y, r.from_z};
    ec = '{r.end_w, r.end_x, r.end_y, r.end_z};
    t = longint'(r.blend);
    s = 0;
    for (int i = 0; i < 4; i++) begin
      v = longint'(fc[i]) * 65536 + t * (longint'(ec[i]) - longint'(fc[i]));
      m[i] = (v + 32768) >>> 16;
      mag = (m[i] < 0) ? -m[i] : m[i];
      s += mag * mag;
    end
    q = '0;
    if (s == 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    s_wide = s;
    for (int i = 0; i < 4; i++) begin
      mag = (m[i] < 0) ? -m[i] : m[i];
      target = mag * mag;
      target = target << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        k_wide = 2 * mid - 1;
        if (s_wide * k_wide * k_wide <= target) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      oc[i] = (m[i] < 0) ? qnl_pkg::comp_t'(-lo) : qnl_pkg::comp_t'(lo);
    end
    q.out_w = oc[0];
    q.out_x = oc[1];
    q.out_y = oc[2];
    q.out_z = oc[3];
    q.degenerate = 1'b0;
    return q;
  endfunction

  function automatic qnl_pkg::req_t make_request(input int fw, input int fx, input int fy,
                                                 input int fz, input int ew, input int ex,
                                                 input int ey, input int ez, input int t);
    qnl_pkg::req_t r;
    r.from_w = qnl_pkg::comp_t'(fw);
    r.from_x = qnl_pkg::comp_t'(fx);
    r.from_y = qnl_pkg::comp_t'(fy);
    r.from_z = qnl_pkg::comp_t'(fz);
    r.end_w  = qnl_pkg::comp_t'(ew);
    r.end_x  = qnl_pkg::comp_t'(ex);
    r.end_y  = qnl_pkg::comp_t'(ey);
    r.end_z  = qnl_pkg::comp_t'(ez);
    r.blend  = t[qnl_pkg::BLEND_W-1:0];
    return r;
  endfunction

  // Mostly unit-range quaternions, with raw bit patterns, near-cancelling pairs
  // and tiny components mixed in.
  function automatic qnl_pkg::req_t random_request();
    int f[4];
    int e[4];
    int t;
    int kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 4; i++) begin
      if (kind < 70) begin
        f[i] = int'($urandom_range(0, 32768)) - 16384;
        e[i] = int'($urandom_range(0, 32768)) - 16384;
      end else if (kind < 85) begin
        f[i] = int'($urandom_range(0, 65535)) - 32768;
        e[i] = int'($urandom_range(0, 65535)) - 32768;
      end else if (kind < 95) begin
        f[i] = int'($urandom_range(0, 32768)) - 16384;
        e[i] = -f[i] + int'($urandom_range(0, 4)) - 2;
      end else begin
        f[i] = int'($urandom_range(0, 6)) - 3;
        e[i] = int'($urandom_range(0, 6)) - 3;
      end
    end
    if (kind < 70) begin
      t = $urandom_range(0, 65536);
    end else if (kind < 85) begin
      t = $urandom_range(0, 131071);
    end else if (kind < 95) begin
      t = 32768 + int'($urandom_range(0, 4)) - 2;
    end else begin
      t = $urandom_range(0, 131071);
    end
    return make_request(f[0], f[1], f[2], f[3], e[0], e[1], e[2], e[3], t);
  endfunction

  task automatic send_request(input qnl_pkg::req_t r);
    int gap;
    gap = sender_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= r;
    do @(posedge clk); while (!item_ch.ready);
    pending_results.push_back(blend_and_normalize(r));
  endtask

  task automatic test_directed();
    send_request(make_request(16384, 0, 0, 0, 16384, 0, 0, 0, 0));
    send_request(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
    send_request(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 65536));
    send_request(make_request(16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384, 32768));
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 65536));
    send_request(make_request(1, 0, 0, 0, 0, 0, 0, 0, 65535));
    send_request(make_request(1, 0, 0, 0, 0, 0, 0, 0, 32768));
    send_request(make_request(-1, 0, 0, 0, 0, 0, 0, 0, 32768));
    send_request(make_request(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                              131071));
    send_request(make_request(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                              131071));
    send_request(make_request(-32768, 0, 0, 0, -32768, 0, 0, 0, 0));
    send_request(make_request(0, 0, 0, -5, 0, 0, 0, -5, 1));
    send_request(make_request(0, 8192, -8192, 8192, 8192, 0, 0, -8192, 16384));
    send_request(make_request(100, 200, 300, 400, -400, -300, -200, -100, 65536));
    send_request(make_request(16384, -16384, 16384, -16384, 0, 0, 0, 0, 65536));
    send_request(make_request(16384, 0, 0, 0, 16383, 1, 0, 0, 1));
    send_request(make_request(1, 1, 1, 1, 1, 1, 1, 1, 0));
    send_request(make_request(0, 0, 0, 1, 0, 0, 1, 0, 65536));
    send_request(make_request(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 131071));
    send_request(make_request(-16384, 16384, -16384, 16384, 16384, -16384, 16384, -16384,
                              98304));
  endtask

  task automatic test_random_blends();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    repeat (280) send_request(random_request());
  endtask

  task automatic test_back_to_back();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    repeat (60) send_request(random_request());
  endtask

  task automatic test_output_stall();
    sender_idle = 1'b0;
    receiver_idle = 1'b1;
    receiver_hold = 400;
    repeat (90) send_request(random_request());
  endtask

  initial begin
    int gap;
    int hold;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      hold = receiver_hold;
      receiver_hold = 0;
      gap = receiver_idle ? $urandom_range(0, 11) : 0;
      if (hold + gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold + gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, result_ch.data);
      end else begin
        want = pending_results.pop_front();
        want_c = '{want.out_w, want.out_x, want.out_y, want.out_z};
        got_c = '{result_ch.data.out_w, result_ch.data.out_x, result_ch.data.out_y,
                  result_ch.data.out_z};
        for (int i = 0; i < 4; i++) begin
          if (got_c[i] !== want_c[i]) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, lane_name[i],
                     want_c[i], got_c[i]);
          end
        end
        if (result_ch.data.degenerate !== want.degenerate) begin
          mismatch_count++;
          $display("%0t: degenerate mismatch, expected %0b, actual %0b", $time,
                   want.degenerate, result_ch.data.degenerate);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    receiver_hold = 0;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_blends();
    test_back_to_back();
    test_output_stall();
    item_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
